### hw/rtl/uclr_pkg.sv
// ----------------------------------------------------------------------------
// uclr_pkg: Shared types and constants for the command line recognizer.
// Holds the request and result payload types, the request and result codes,
// and the keyword spellings used by the line decoder.
// ----------------------------------------------------------------------------
package uclr_pkg;

  // Request kinds carried in the command field.
  localparam logic CmdChar    = 1'b0;
  localparam logic CmdProcess = 1'b1;

  // Codes carried in the decoded_command field of a result.
  localparam logic [2:0] DecNone    = 3'd0;
  localparam logic [2:0] DecGet     = 3'd1;
  localparam logic [2:0] DecLast    = 3'd2;
  localparam logic [2:0] DecClear   = 3'd3;
  localparam logic [2:0] DecMeasure = 3'd4;

  // Status codes of a result.
  localparam logic StatusOk       = 1'b0;
  localparam logic StatusOverflow = 1'b1;

  // Line terminators.
  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  // Only the head of a line is stored; longer lines never decode.
  localparam int unsigned HeadDepth = 7;
  localparam int unsigned HeadIdxW  = 3;

  // Keyword spellings. Element 0 holds the first character of the keyword.
  localparam logic [2:0][7:0] KwGet     = {"T", "E", "G"};
  localparam logic [3:0][7:0] KwLast    = {"T", "S", "A", "L"};
  localparam logic [4:0][7:0] KwClear   = {"R", "A", "E", "L", "C"};
  localparam logic [6:0][7:0] KwMeasure = {"E", "R", "U", "S", "A", "E", "M"};

  // Incoming request payload.
  typedef struct packed {
    logic       command;
    logic [7:0] char_byte;
  } in_req_t;

  // Outgoing result payload.
  typedef struct packed {
    logic       status;
    logic [2:0] decoded_command;
  } out_rsp_t;

endpackage

### hw/rtl/uart_command_line_recognizer.sv
// ----------------------------------------------------------------------------
// uart_command_line_recognizer: Line assembler and keyword recognizer.
// Collects received characters into a line and, on a process request,
// reports a pending overflow, decodes the completed line to a keyword, or reports no keyword.
// ----------------------------------------------------------------------------
// A process request passes through the input register and then the result
// register before its result is presented.
// Throughput: one request per cycle; the single state update step after the
// input register sets this rate, and only a stalled result slows it.
// Reset: rst_ni clears the line length, the completion and overflow flags
// and both valid flags; the stored line head is not cleared.
module uart_command_line_recognizer #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uclr_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uclr_pkg::out_rsp_t out_data_o
);

  localparam int unsigned LenW = $clog2(LINE_MAX);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_MAX - 1);

  // Input register.
  logic              in_valid_q, in_valid_d;
  uclr_pkg::in_req_t in_q;

  // Line state.
  logic [uclr_pkg::HeadDepth-1:0][7:0] head_q, head_d;
  logic [LenW-1:0]                     len_q, len_d;
  logic                                complete_q, complete_d;
  logic                                ovf_q, ovf_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  uclr_pkg::out_rsp_t out_q, out_d;

  logic       adv;
  logic       is_process;
  logic       is_term;
  logic [2:0] dec_cmd;

  // The held request moves on unless it needs the result slot and that is stalled.
  assign is_process = (in_q.command == uclr_pkg::CmdProcess);
  assign adv        = in_valid_q && (!is_process || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // Input register control.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  // Keyword decode of the completed line.
  always_comb begin
    dec_cmd = uclr_pkg::DecNone;
    if (len_q == LenW'(3) && head_q[2:0] == uclr_pkg::KwGet) begin
      dec_cmd = uclr_pkg::DecGet;
    end else if (len_q == LenW'(4) && head_q[3:0] == uclr_pkg::KwLast) begin
      dec_cmd = uclr_pkg::DecLast;
    end else if (len_q == LenW'(5) && head_q[4:0] == uclr_pkg::KwClear) begin
      dec_cmd = uclr_pkg::DecClear;
    end else if (len_q == LenW'(7) && head_q == uclr_pkg::KwMeasure) begin
      dec_cmd = uclr_pkg::DecMeasure;
    end
  end

  assign is_term = (in_q.char_byte == uclr_pkg::CharCr) ||
                   (in_q.char_byte == uclr_pkg::CharLf);

  // Line state update and result formation.
  always_comb begin
    head_d      = head_q;
    len_d       = len_q;
    complete_d  = complete_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (adv) begin
      if (!is_process) begin
        // Characters are dropped while a completed line waits.
        if (!complete_q) begin
          if (is_term) begin
            if (len_q != '0) begin
              complete_d = 1'b1;
            end
          end else if (len_q < LenLast) begin
            if (len_q < LenW'(uclr_pkg::HeadDepth)) begin
              head_d[len_q[uclr_pkg::HeadIdxW-1:0]] = in_q.char_byte;
            end
            len_d = len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
            len_d = '0;
          end
        end
      end else begin
        out_valid_d = 1'b1;
        if (ovf_q) begin
          // An overflow is reported first; a completed line stays pending.
          ovf_d                 = 1'b0;
          out_d.status          = uclr_pkg::StatusOverflow;
          out_d.decoded_command = uclr_pkg::DecNone;
        end else begin
          out_d.status          = uclr_pkg::StatusOk;
          out_d.decoded_command = uclr_pkg::DecNone;
          if (complete_q) begin
            out_d.decoded_command = dec_cmd;
            len_d                 = '0;
            complete_d            = 1'b0;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      len_q       <= '0;
      complete_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      len_q       <= len_d;
      complete_q  <= complete_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    head_q <= head_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The line length never passes the last storable position.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LenLast)
    else $error("line length out of range");

  // A completed line is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) complete_q |-> len_q != '0)
    else $error("completed line is empty");

  // A process request with an overflow pending reports it and clears the flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_process && ovf_q) |=>
      (!ovf_q && out_valid_o && out_data_o.status == uclr_pkg::StatusOverflow))
    else $error("overflow not reported");

  // Processing a completed line without overflow empties the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_process && !ovf_q && complete_q) |=> (!complete_q && len_q == '0))
    else $error("line not cleared after decode");

  // An overflow result never carries a keyword.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == uclr_pkg::StatusOverflow) |->
      out_data_o.decoded_command == uclr_pkg::DecNone)
    else $error("overflow result carries a keyword");
`endif

endmodule
